[src/text_console_glyph_renderer_assert.svh]
// Assertion macros shared by the text console glyph renderer.
// Needs nothing else; included by the top level.
`ifndef TEXT_CONSOLE_GLYPH_RENDERER_ASSERT_SVH
`define TEXT_CONSOLE_GLYPH_RENDERER_ASSERT_SVH

// Same-cycle implication, checked out of reset.
`define TCGR_ASSERT_IMPLIES(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("tcgr: same-cycle check failed");

// Next-cycle implication, checked out of reset.
`define TCGR_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("tcgr: next-cycle check failed");

`endif

[src/tcgr_pkg.sv]
`timescale 1ns / 1ps
// Types, constants and the colour palette of the text console glyph renderer.
// Depends on nothing; the top level, front, back and both testbench files import it.
`default_nettype none

package tcgr_pkg;

	localparam int MAX_GLYPH_HEIGHT = 32;
	localparam int GLYPH_COUNT      = 256;
	localparam int GLYPH_WIDTH      = 8;
	localparam int GLYPH_SHIFT      = $clog2(GLYPH_WIDTH);
	// Log2 of the bytes covered by one glyph cell on a line, at four bytes a pixel.
	localparam int CELL_SHIFT       = $clog2(GLYPH_WIDTH * 4);
	localparam int GROUP_BYTES      = 16;

	localparam int FONT_DEPTH = 8192;
	localparam int FONT_AW    = $clog2(FONT_DEPTH);
	localparam int COL_W      = 9;
	localparam int ROW_W      = 12;
	localparam int Y_W        = $clog2(MAX_GLYPH_HEIGHT);
	localparam int QUEUE_DEPTH = 4;

	localparam int SCREEN_W = 13;
	localparam int PITCH_W  = 15;
	localparam int GH_W     = 6;
	localparam int BPP_W    = 6;
	localparam int COLOR_W  = 24;
	localparam int OFFS_W   = 26;
	localparam int CFG_DATA_W  = 15;
	localparam int CFG_INDEX_W = 3;

	localparam logic [BPP_W-1:0] REQUIRED_BPP = BPP_W'(32);
	localparam logic [7:0] CHAR_NEWLINE = 8'd10;
	localparam logic [7:0] CHAR_TAB     = 8'd9;
	localparam logic       CMD_LOAD     = 1'b0;
	localparam logic       CMD_PUT      = 1'b1;

	typedef enum logic [CFG_INDEX_W-1:0] {
		REG_SCREEN_WIDTH   = 3'd0,
		REG_SCREEN_HEIGHT  = 3'd1,
		REG_LINE_PITCH     = 3'd2,
		REG_GLYPH_HEIGHT   = 3'd3,
		REG_BITS_PER_PIXEL = 3'd4,
		REG_TEXT_COLOR     = 3'd5
	} cfg_reg_e;

	typedef struct packed {
		logic [SCREEN_W-1:0] screen_width;
		logic [SCREEN_W-1:0] screen_height;
		logic [PITCH_W-1:0]  line_pitch;
		logic [GH_W-1:0]     glyph_height;
		logic [BPP_W-1:0]    bits_per_pixel;
		logic [7:0]          text_color;
	} tcgr_cfg_t;

	typedef struct packed {
		logic               cmd;
		logic [7:0]         char_code;
		logic [COLOR_W-1:0] fg_color;
		logic [COLOR_W-1:0] bg_color;
		logic [FONT_AW-1:0] font_address;
		logic [7:0]         font_bits;
	} tcgr_in_t;

	typedef struct packed {
		logic [OFFS_W-1:0]  pixel_offset;
		logic [COLOR_W-1:0] pixel_a;
		logic [COLOR_W-1:0] pixel_b;
		logic [COLOR_W-1:0] pixel_c;
		logic [COLOR_W-1:0] pixel_d;
		logic               last_write;
	} tcgr_out_t;

	// Queue entry: either a font line write or a glyph to draw.
	typedef struct packed {
		logic               is_draw;
		logic [FONT_AW-1:0] addr;
		logic [7:0]         bits;
		logic [COLOR_W-1:0] fg;
		logic [COLOR_W-1:0] bg;
		logic [COL_W-1:0]   col;
		logic [ROW_W-1:0]   row;
	} tcgr_entry_t;

	typedef enum logic [2:0] {
		BK_IDLE,
		BK_ROWMUL,
		BK_BASE,
		BK_LEFT,
		BK_RIGHT
	} back_state_t;

	// Sixteen-colour text palette.
	function automatic logic [COLOR_W-1:0] palette(input logic [3:0] idx);
		logic [COLOR_W-1:0] c;
		unique case (idx)
			4'h0: c = 24'h000000;
			4'h1: c = 24'h0000AA;
			4'h2: c = 24'h00AA00;
			4'h3: c = 24'h00AAAA;
			4'h4: c = 24'hAA0000;
			4'h5: c = 24'hAA00AA;
			4'h6: c = 24'hAA5500;
			4'h7: c = 24'hAAAAAA;
			4'h8: c = 24'h555555;
			4'h9: c = 24'h5555FF;
			4'hA: c = 24'h55FF55;
			4'hB: c = 24'h55FFFF;
			4'hC: c = 24'hFF5555;
			4'hD: c = 24'hFF55FF;
			4'hE: c = 24'hFFFF55;
			4'hF: c = 24'hFFFFFF;
		endcase
		return c;
	endfunction

endpackage

`default_nettype wire

[src/tcgr_stream_if.sv]
`timescale 1ns / 1ps
// Valid/ready stream interface with a typed payload.
// Depends on nothing; the payload type is set where it is instantiated.
`default_nettype none

interface tcgr_stream_if #(parameter type payload_t = logic);
	logic     valid;
	logic     ready;
	payload_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

`default_nettype wire

[src/text_console_glyph_renderer.sv]
// A drawn character passes the queue and the back end's idle, row-multiply and base
// states before its first pixel group is registered; newlines, tabs and dropped puts end at the front.
// The back end takes one character at a time, with two setup multiplies after the pop,
// then one four-pixel group a cycle while the output is not stalled.
// Reset clears the cursor, the queue and the output and loads the register defaults;
// the font store is not cleared and holds nothing defined until written.
`timescale 1ns / 1ps
`default_nettype none
`include "text_console_glyph_renderer_assert.svh"

module text_console_glyph_renderer #(
	parameter int QUEUE_DEPTH = tcgr_pkg::QUEUE_DEPTH
) (
	input  wire                            clk,
	input  wire                            arst_n,
	input  wire                            cfg_write,
	input  wire [tcgr_pkg::CFG_INDEX_W-1:0] cfg_index,
	input  wire [tcgr_pkg::CFG_DATA_W-1:0]  cfg_data,
	tcgr_stream_if.sink                    char_stream,
	tcgr_stream_if.source                  pixel_stream
);
	import tcgr_pkg::*;

	tcgr_cfg_t   cfg_q;
	logic        q_push;
	logic        q_pop;
	logic        q_full;
	logic        q_empty;
	tcgr_entry_t q_push_data;
	tcgr_entry_t q_pop_data;

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.screen_width   <= SCREEN_W'(640);
			cfg_q.screen_height  <= SCREEN_W'(480);
			cfg_q.line_pitch     <= PITCH_W'(2560);
			cfg_q.glyph_height   <= GH_W'(16);
			cfg_q.bits_per_pixel <= BPP_W'(32);
			cfg_q.text_color     <= 8'd7;
		end else if (cfg_write) begin
			unique case (cfg_index)
				REG_SCREEN_WIDTH:   cfg_q.screen_width   <= cfg_data[SCREEN_W-1:0];
				REG_SCREEN_HEIGHT:  cfg_q.screen_height  <= cfg_data[SCREEN_W-1:0];
				REG_LINE_PITCH:     cfg_q.line_pitch     <= cfg_data[PITCH_W-1:0];
				REG_GLYPH_HEIGHT:   cfg_q.glyph_height   <= cfg_data[GH_W-1:0];
				REG_BITS_PER_PIXEL: cfg_q.bits_per_pixel <= cfg_data[BPP_W-1:0];
				REG_TEXT_COLOR:     cfg_q.text_color     <= cfg_data[7:0];
				default: ;
			endcase
		end
	end

	// Front end: cursor and classification.
	tcgr_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg        (cfg_q),
		.char_stream(char_stream),
		.push       (q_push),
		.push_entry (q_push_data),
		.full       (q_full)
	);

	// Queue between front and back.
	tcgr_fifo #(
		.DEPTH  (QUEUE_DEPTH),
		.entry_t(tcgr_entry_t)
	) u_fifo (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (q_push),
		.push_data(q_push_data),
		.full     (q_full),
		.pop      (q_pop),
		.pop_data (q_pop_data),
		.empty    (q_empty)
	);

	// Back end: font store and glyph expansion.
	tcgr_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg         (cfg_q),
		.pop         (q_pop),
		.entry       (q_pop_data),
		.empty       (q_empty),
		.pixel_stream(pixel_stream)
	);

	// The front never writes into a full queue, the back never reads an empty one.
	`TCGR_ASSERT_IMPLIES(a_push_has_room, clk, arst_n, q_push, !q_full)
	`TCGR_ASSERT_IMPLIES(a_pop_has_entry, clk, arst_n, q_pop, !q_empty)
	// A pixel group on offer stays on offer, unchanged, until it is taken.
	`TCGR_ASSERT_NEXT(a_hold_while_stalled, clk, arst_n,
		pixel_stream.valid && !pixel_stream.ready, pixel_stream.valid)
	`TCGR_ASSERT_NEXT(a_data_while_stalled, clk, arst_n,
		pixel_stream.valid && !pixel_stream.ready, $stable(pixel_stream.data))

endmodule

`default_nettype wire

[src/tcgr_fifo.sv]
`timescale 1ns / 1ps
// Small register queue between the front and the back of the renderer.
// Depends on nothing but its parameters.
`default_nettype none

module tcgr_fifo #(
	parameter int DEPTH = 4,
	parameter type entry_t = logic
) (
	input  wire    clk,
	input  wire    arst_n,
	input  wire    push,
	input  entry_t push_data,
	output logic   full,
	input  wire    pop,
	output entry_t pop_data,
	output logic   empty
);

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	entry_t             slots_q [DEPTH];
	logic [PTR_W-1:0]   wr_ptr_q;
	logic [PTR_W-1:0]   rd_ptr_q;
	logic [CNT_W-1:0]   count_q;

	assign full     = (count_q == CNT_W'(DEPTH));
	assign empty    = (count_q == '0);
	assign pop_data = slots_q[rd_ptr_q];

	// Pointers and fill count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	// Entry storage.
	always_ff @(posedge clk) begin
		if (push) begin
			slots_q[wr_ptr_q] <= push_data;
		end
	end

endmodule

`default_nettype wire

[src/tcgr_front.sv]
`timescale 1ns / 1ps
// Front end: accepts commands, keeps the text cursor and queues work.
// Depends on tcgr_pkg and tcgr_stream_if.
`default_nettype none

module tcgr_front (
	input  wire                 clk,
	input  wire                 arst_n,
	input  tcgr_pkg::tcgr_cfg_t cfg,
	tcgr_stream_if.sink         char_stream,
	output logic                push,
	output tcgr_pkg::tcgr_entry_t push_entry,
	input  wire                 full
);
	import tcgr_pkg::*;

	localparam int COLS_W = SCREEN_W - GLYPH_SHIFT;
	localparam int PROD_W = ROW_W + 1 + GH_W;

	logic [COL_W-1:0]   col_q;
	logic [ROW_W-1:0]   row_q;
	logic [COLS_W-1:0]  cols;
	logic               cfg_ok;
	logic [ROW_W:0]     row_plus2;
	logic [PROD_W-1:0]  row_prod;
	logic               row_wrap;
	logic [ROW_W-1:0]   row_next;
	logic [COL_W:0]     tab_col;
	logic [COL_W:0]     adv_col;
	logic [COL_W:0]     new_col;
	logic               col_wrap;
	logic               accept;
	logic               is_put;
	logic               is_newline;
	logic               is_tab;
	logic [7:0]         glyph;
	logic [FONT_AW:0]   glyph_prod;
	logic               use_palette;
	tcgr_in_t           item;

	assign item = char_stream.data;
	assign char_stream.ready = !full;
	assign accept = char_stream.valid && !full;

	// Configuration check; a row count of zero means height below glyph height.
	assign cols   = cfg.screen_width[SCREEN_W-1:GLYPH_SHIFT];
	assign cfg_ok = (cfg.glyph_height != '0)
		&& (cfg.glyph_height <= GH_W'(MAX_GLYPH_HEIGHT))
		&& (cols != '0)
		&& !(cfg.screen_height < SCREEN_W'(cfg.glyph_height))
		&& (cfg.bits_per_pixel == REQUIRED_BPP);

	// Row advance: row + 1 reaches the row count when height < (row + 2) * glyph height.
	assign row_plus2 = {1'b0, row_q} + (ROW_W + 1)'(2);
	assign row_prod  = PROD_W'(row_plus2) * PROD_W'(cfg.glyph_height);
	assign row_wrap  = (PROD_W'(cfg.screen_height) < row_prod) || (row_q == '1);
	assign row_next  = row_wrap ? '0 : row_q + 1'b1;

	// Column advance for a tab or a drawn glyph.
	assign tab_col  = ({1'b0, col_q} + (COL_W + 1)'(GLYPH_WIDTH))
		& ~(COL_W + 1)'(GLYPH_WIDTH - 1);
	assign adv_col  = {1'b0, col_q} + 1'b1;
	assign new_col  = is_tab ? tab_col : adv_col;
	assign col_wrap = ((COLS_W + 1)'(new_col) >= (COLS_W + 1)'(cols)) || new_col[COL_W];

	// Classification of the incoming item.
	assign is_put     = (item.cmd == CMD_PUT);
	assign is_newline = (item.char_code == CHAR_NEWLINE);
	assign is_tab     = (item.char_code == CHAR_TAB);

	assign push = accept && (!is_put || (cfg_ok && !is_newline && !is_tab));

	// Glyph base address in the font store.
	assign glyph = ({1'b0, item.char_code} < 9'(GLYPH_COUNT)) ? item.char_code : 8'd0;
	assign glyph_prod = (FONT_AW + 1)'(glyph) * (FONT_AW + 1)'(cfg.glyph_height);
	assign use_palette = (item.fg_color == '0) || (item.bg_color == '0);

	// Queue entry.
	always_comb begin
		push_entry.is_draw = is_put;
		push_entry.addr    = is_put ? glyph_prod[FONT_AW-1:0] : item.font_address;
		push_entry.bits    = item.font_bits;
		push_entry.fg      = use_palette ? palette(cfg.text_color[3:0]) : item.fg_color;
		push_entry.bg      = use_palette ? palette(cfg.text_color[7:4]) : item.bg_color;
		push_entry.col     = col_q;
		push_entry.row     = row_q;
	end

	// Cursor registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			row_q <= '0;
		end else if (accept && is_put && cfg_ok) begin
			if (is_newline || col_wrap) begin
				col_q <= '0;
				row_q <= row_next;
			end else begin
				col_q <= new_col[COL_W-1:0];
			end
		end
	end

endmodule

`default_nettype wire

[src/tcgr_back.sv]
`timescale 1ns / 1ps
// Back end: holds the font store, expands glyphs into four-pixel writes.
// Depends on tcgr_pkg and tcgr_stream_if.
`default_nettype none

module tcgr_back (
	input  wire                   clk,
	input  wire                   arst_n,
	input  tcgr_pkg::tcgr_cfg_t   cfg,
	output logic                  pop,
	input  tcgr_pkg::tcgr_entry_t entry,
	input  wire                   empty,
	tcgr_stream_if.source         pixel_stream
);
	import tcgr_pkg::*;

	localparam int RH_W   = ROW_W + GH_W;
	localparam int LINE_W = RH_W + PITCH_W;

	back_state_t        state_q;
	back_state_t        state_d;
	tcgr_entry_t        ent_q;
	logic               latch_ent;
	logic               mem_we;
	logic               step_line;
	logic               load_out;
	logic [RH_W-1:0]    rh_q;
	logic [LINE_W-1:0]  line_prod;
	logic [OFFS_W-1:0]  base_q;
	logic [Y_W-1:0]     y_q;
	logic               last_line;
	logic [FONT_AW-1:0] rd_addr_q;
	logic [FONT_AW-1:0] rd_addr_d;
	logic [7:0]         rdata_q;
	logic [7:0]         font_mem [FONT_DEPTH];
	logic               out_valid_q;
	logic               out_free;
	tcgr_out_t          out_q;
	tcgr_out_t          out_d;

	assign out_free  = !out_valid_q || pixel_stream.ready;
	assign line_prod = LINE_W'(rh_q) * LINE_W'(cfg.line_pitch);
	assign last_line = (GH_W'(y_q) + 1'b1) == cfg.glyph_height;

	assign pixel_stream.valid = out_valid_q;
	assign pixel_stream.data  = out_q;

	// Sequencer: font loads, or two setup steps then left and right half of each line.
	always_comb begin
		state_d   = state_q;
		pop       = 1'b0;
		mem_we    = 1'b0;
		latch_ent = 1'b0;
		step_line = 1'b0;
		load_out  = 1'b0;
		rd_addr_d = rd_addr_q;
		out_d     = out_q;
		unique case (state_q)
			BK_IDLE: begin
				if (!empty) begin
					pop = 1'b1;
					if (entry.is_draw) begin
						latch_ent = 1'b1;
						state_d   = BK_ROWMUL;
					end else begin
						mem_we = 1'b1;
					end
				end
			end
			BK_ROWMUL: begin
				state_d = BK_BASE;
			end
			BK_BASE: begin
				rd_addr_d = ent_q.addr;
				state_d   = BK_LEFT;
			end
			BK_LEFT: begin
				if (out_free) begin
					load_out           = 1'b1;
					out_d.pixel_offset = base_q;
					out_d.pixel_a      = rdata_q[7] ? ent_q.fg : ent_q.bg;
					out_d.pixel_b      = rdata_q[6] ? ent_q.fg : ent_q.bg;
					out_d.pixel_c      = rdata_q[5] ? ent_q.fg : ent_q.bg;
					out_d.pixel_d      = rdata_q[4] ? ent_q.fg : ent_q.bg;
					out_d.last_write   = 1'b0;
					state_d            = BK_RIGHT;
				end
			end
			BK_RIGHT: begin
				if (out_free) begin
					load_out           = 1'b1;
					out_d.pixel_offset = base_q + OFFS_W'(GROUP_BYTES);
					out_d.pixel_a      = rdata_q[3] ? ent_q.fg : ent_q.bg;
					out_d.pixel_b      = rdata_q[2] ? ent_q.fg : ent_q.bg;
					out_d.pixel_c      = rdata_q[1] ? ent_q.fg : ent_q.bg;
					out_d.pixel_d      = rdata_q[0] ? ent_q.fg : ent_q.bg;
					out_d.last_write   = last_line;
					if (last_line) begin
						state_d = BK_IDLE;
					end else begin
						rd_addr_d = rd_addr_q + 1'b1;
						step_line = 1'b1;
						state_d   = BK_LEFT;
					end
				end
			end
			default: state_d = BK_IDLE;
		endcase
	end

	// Control state and output valid.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= BK_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (load_out) begin
				out_valid_q <= 1'b1;
			end else if (pixel_stream.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Datapath: row product, line base offset, line counter, output register.
	always_ff @(posedge clk) begin
		if (latch_ent) begin
			ent_q <= entry;
		end
		rh_q <= RH_W'(ent_q.row) * RH_W'(cfg.glyph_height);
		if (state_q == BK_BASE) begin
			base_q <= line_prod[OFFS_W-1:0] + (OFFS_W'(ent_q.col) << CELL_SHIFT);
			y_q    <= '0;
		end else if (step_line) begin
			base_q <= base_q + OFFS_W'(cfg.line_pitch);
			y_q    <= y_q + 1'b1;
		end
		rd_addr_q <= rd_addr_d;
		if (load_out) begin
			out_q <= out_d;
		end
	end

	// Font store: written by load entries, read one line ahead of use.
	always_ff @(posedge clk) begin
		if (mem_we) begin
			font_mem[entry.addr] <= entry.bits;
		end
		rdata_q <= font_mem[rd_addr_d];
	end

endmodule

`default_nettype wire

[tb/sv/glyph_write_checker.sv]
`timescale 1ns / 1ps
// Checker for the text console glyph renderer: mirrors the cursor, the font
// store and the registers, and compares each pixel group. Needs tcgr_pkg.

module glyph_write_checker
	import tcgr_pkg::*;
(
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   cfg_write,
	input  logic [CFG_INDEX_W-1:0] cfg_index,
	input  logic [CFG_DATA_W-1:0]  cfg_data,
	input  logic                   char_valid,
	input  logic                   char_ready,
	input  tcgr_in_t               char_item,
	input  logic                   pixel_valid,
	input  logic                   pixel_ready,
	input  tcgr_out_t              pixel_group,
	output int                     groups_owed,
	output int                     mismatches
);

	tcgr_cfg_t        regs;
	logic [COL_W-1:0] col;
	logic [ROW_W-1:0] row;
	logic [7:0]       font_copy [FONT_DEPTH];
	tcgr_out_t        groups_due [$];
	int               fault_count = 0;

	assign mismatches = fault_count;

	function automatic logic [COLOR_W-1:0] text_palette(input logic [3:0] idx);
		logic [COLOR_W-1:0] rgb;
		case (idx)
			4'h0: rgb = 24'h000000;
			4'h1: rgb = 24'h0000AA;
			4'h2: rgb = 24'h00AA00;
			4'h3: rgb = 24'h00AAAA;
			4'h4: rgb = 24'hAA0000;
			4'h5: rgb = 24'hAA00AA;
			4'h6: rgb = 24'hAA5500;
			4'h7: rgb = 24'hAAAAAA;
			4'h8: rgb = 24'h555555;
			4'h9: rgb = 24'h5555FF;
			4'hA: rgb = 24'h55FF55;
			4'hB: rgb = 24'h55FFFF;
			4'hC: rgb = 24'hFF5555;
			4'hD: rgb = 24'hFF55FF;
			4'hE: rgb = 24'hFFFF55;
			default: rgb = 24'hFFFFFF;
		endcase
		return rgb;
	endfunction

	// The row wraps at the row count or at the width of the row counter.
	task automatic advance_row(input int unsigned rows);
		int unsigned r;
		r = int'(row) + 1;
		if (r >= rows || r >= (1 << ROW_W))
			r = 0;
		row = ROW_W'(r);
	endtask

	task automatic place_column(input int unsigned c, input int unsigned cols,
			input int unsigned rows);
		if (c >= cols || c >= (1 << COL_W)) begin
			col = '0;
			advance_row(rows);
		end else begin
			col = COL_W'(c);
		end
	endtask

	// Works out the pixel groups that one accepted character transfer causes.
	task automatic render_item(input tcgr_in_t it);
		int unsigned       h, cols, rows, lines_down;
		longint unsigned   line_base;
		logic [COLOR_W-1:0] ink, paper;
		logic [COLOR_W-1:0] px [4];
		logic [7:0]        bits;
		tcgr_out_t         g;
		if (it.cmd == CMD_LOAD) begin
			font_copy[it.font_address] = it.font_bits;
			return;
		end
		h = regs.glyph_height;
		if (h == 0 || h > MAX_GLYPH_HEIGHT)
			return;
		cols = regs.screen_width / GLYPH_WIDTH;
		rows = regs.screen_height / h;
		if (cols == 0 || rows == 0 || regs.bits_per_pixel != REQUIRED_BPP)
			return;
		if (it.char_code == CHAR_NEWLINE) begin
			col = '0;
			advance_row(rows);
			return;
		end
		if (it.char_code == CHAR_TAB) begin
			place_column((int'(col) + GLYPH_WIDTH) & ~(GLYPH_WIDTH - 1), cols, rows);
			return;
		end
		ink = it.fg_color;
		paper = it.bg_color;
		// Either colour left at zero hands both over to the palette.
		if (ink == '0 || paper == '0) begin
			ink = text_palette(regs.text_color[3:0]);
			paper = text_palette(regs.text_color[7:4]);
		end
		// Every eight-bit code lies inside the font, so the code is the glyph.
		for (int y = 0; y < h; y++) begin
			bits = font_copy[(int'(it.char_code) * h + y) % FONT_DEPTH];
			lines_down = int'(row) * h + y;
			line_base = longint'(lines_down) * regs.line_pitch + int'(col) * GLYPH_WIDTH * 4;
			for (int hf = 0; hf < 2; hf++) begin
				for (int k = 0; k < 4; k++)
					px[k] = bits[7 - (hf * 4 + k)] ? ink : paper;
				g.pixel_offset = OFFS_W'(line_base + hf * GROUP_BYTES);
				g.pixel_a = px[0];
				g.pixel_b = px[1];
				g.pixel_c = px[2];
				g.pixel_d = px[3];
				g.last_write = (y == h - 1 && hf == 1);
				groups_due.push_back(g);
			end
		end
		place_column(int'(col) + 1, cols, rows);
	endtask

	task automatic compare_field(input string what, input logic [31:0] want,
			input logic [31:0] got);
		if (want !== got) begin
			$display("%0t: %s expected %h, got %h", $time, what, want, got);
			fault_count++;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		tcgr_out_t want;
		if (!arst_n) begin
			regs.screen_width = 13'd640;
			regs.screen_height = 13'd480;
			regs.line_pitch = 15'd2560;
			regs.glyph_height = 6'd16;
			regs.bits_per_pixel = 6'd32;
			regs.text_color = 8'd7;
			col = '0;
			row = '0;
			groups_due.delete();
			groups_owed <= 0;
		end else begin
			// Register writes only come while nothing is in flight.
			if (cfg_write) begin
				case (cfg_index)
					REG_SCREEN_WIDTH:   regs.screen_width = cfg_data[SCREEN_W-1:0];
					REG_SCREEN_HEIGHT:  regs.screen_height = cfg_data[SCREEN_W-1:0];
					REG_LINE_PITCH:     regs.line_pitch = cfg_data[PITCH_W-1:0];
					REG_GLYPH_HEIGHT:   regs.glyph_height = cfg_data[GH_W-1:0];
					REG_BITS_PER_PIXEL: regs.bits_per_pixel = cfg_data[BPP_W-1:0];
					REG_TEXT_COLOR:     regs.text_color = cfg_data[7:0];
					default: ;
				endcase
			end
			// Each pixel group transfer is held against the oldest expectation.
			if (pixel_valid && pixel_ready) begin
				if (groups_due.size() == 0) begin
					$display("%0t: unexpected pixel group, expected none, got offset %h",
						$time, pixel_group.pixel_offset);
					fault_count++;
				end else begin
					want = groups_due.pop_front();
					compare_field("pixel_offset", want.pixel_offset, pixel_group.pixel_offset);
					compare_field("pixel_a", want.pixel_a, pixel_group.pixel_a);
					compare_field("pixel_b", want.pixel_b, pixel_group.pixel_b);
					compare_field("pixel_c", want.pixel_c, pixel_group.pixel_c);
					compare_field("pixel_d", want.pixel_d, pixel_group.pixel_d);
					compare_field("last_write", want.last_write, pixel_group.last_write);
				end
			end
			if (char_valid && char_ready)
				render_item(char_item);
			groups_owed <= groups_due.size();
		end
	end

endmodule

[tb/sv/testbench.sv]
`timescale 1ns / 1ps
// Top of the glyph renderer testbench: clock, reset, register set-up and
// character stimulus. Needs tcgr_pkg, tcgr_stream_if and glyph_write_checker.

module testbench;
	import tcgr_pkg::*;

	localparam int QUIET_LIMIT = 2000;

	logic                   clk;
	logic                   arst_n;
	logic                   cfg_write;
	logic [CFG_INDEX_W-1:0] cfg_index;
	logic [CFG_DATA_W-1:0]  cfg_data;
	int                     groups_owed;
	int                     mismatches;
	int                     quiet_cycles = 0;

	tcgr_cfg_t   settings;
	bit          font_known [FONT_DEPTH];
	bit          calm = 1'b0;
	bit          hold_output = 1'b0;
	int unsigned gap_pct = 0;
	int unsigned stall_pct = 0;
	int unsigned variety = 2;

	tcgr_stream_if #(.payload_t(tcgr_in_t))  char_if ();
	tcgr_stream_if #(.payload_t(tcgr_out_t)) pixel_if ();

	text_console_glyph_renderer uut (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_write    (cfg_write),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.char_stream  (char_if),
		.pixel_stream (pixel_if)
	);

	glyph_write_checker u_checker (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_write   (cfg_write),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.char_valid  (char_if.valid),
		.char_ready  (char_if.ready),
		.char_item   (char_if.data),
		.pixel_valid (pixel_if.valid),
		.pixel_ready (pixel_if.ready),
		.pixel_group (pixel_if.data),
		.groups_owed (groups_owed),
		.mismatches  (mismatches)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	// Watchdog: too long without any transfer on either channel ends the run.
	always @(posedge clk) begin
		if ((char_if.valid && char_if.ready) || (pixel_if.valid && pixel_if.ready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles == QUIET_LIMIT) begin
			$display("testbench failed");
			$finish;
		end
	end

	// Pixel receiver: random stalls, one long hold-off on request, none when calm.
	initial begin
		forever begin
			if (hold_output) begin
				pixel_if.ready <= 1'b0;
				repeat (400) @(posedge clk);
				hold_output = 1'b0;
			end else if (!calm && $urandom_range(0, 99) < stall_pct) begin
				pixel_if.ready <= 1'b0;
				repeat ($urandom_range(1, 18)) @(posedge clk);
			end else begin
				pixel_if.ready <= 1'b1;
				repeat ($urandom_range(1, 20)) @(posedge clk);
			end
		end
	end

	function automatic tcgr_in_t noise_item();
		tcgr_in_t it;
		it.cmd = 1'($urandom_range(0, 1));
		it.char_code = 8'($urandom);
		it.fg_color = 24'($urandom);
		it.bg_color = 24'($urandom);
		it.font_address = FONT_AW'($urandom);
		it.font_bits = 8'($urandom);
		return it;
	endfunction

	// A put may only name a glyph whose lines at the current height are loaded.
	function automatic bit glyph_loaded(input int unsigned g);
		int unsigned h;
		h = settings.glyph_height;
		if (h == 0 || h > MAX_GLYPH_HEIGHT)
			return 1'b1;
		for (int y = 0; y < h; y++)
			if (!font_known[(g * h + y) % FONT_DEPTH])
				return 1'b0;
		return 1'b1;
	endfunction

	// Glyphs in play: 0 and 255 always, a few in between when variety allows.
	function automatic int unsigned pool_glyph();
		int unsigned k;
		k = $urandom_range(0, variety - 1);
		return (k == variety - 1 && k != 0) ? 255 : k * 37;
	endfunction

	// Mostly font loads that fill in glyphs and puts of loaded glyphs, with
	// cursor moves and the odd stray load anywhere in the store.
	function automatic tcgr_in_t pick_item(input int unsigned turn_pct);
		tcgr_in_t    it;
		int unsigned roll, g, hh, y;
		it = noise_item();
		roll = $urandom_range(0, 99);
		hh = settings.glyph_height;
		if (hh == 0 || hh > MAX_GLYPH_HEIGHT)
			hh = 16;
		g = pool_glyph();
		if (roll < 6) begin
			it.cmd = CMD_LOAD;
		end else if (roll < 6 + turn_pct) begin
			it.cmd = CMD_PUT;
			it.char_code = roll[0] ? CHAR_TAB : CHAR_NEWLINE;
		end else if (roll < 30 + turn_pct || !glyph_loaded(g)) begin
			it.cmd = CMD_LOAD;
			y = $urandom_range(0, hh - 1);
			for (int k = hh; k > 0; k--)
				if (!font_known[(g * hh + k - 1) % FONT_DEPTH])
					y = k - 1;
			it.font_address = FONT_AW'((g * hh + y) % FONT_DEPTH);
		end else begin
			it.cmd = CMD_PUT;
			it.char_code = 8'(g);
			case ($urandom_range(0, 3))
				0: it.fg_color = '0;
				1: it.bg_color = '0;
				default: ;
			endcase
		end
		return it;
	endfunction

	// One character transfer, then perhaps a gap before the next.
	task automatic transfer(input tcgr_in_t it);
		char_if.valid <= 1'b1;
		char_if.data <= it;
		@(posedge clk);
		while (!char_if.ready)
			@(posedge clk);
		if (it.cmd == CMD_LOAD)
			font_known[it.font_address] = 1'b1;
		if (!calm && $urandom_range(0, 99) < gap_pct) begin
			char_if.valid <= 1'b0;
			repeat ($urandom_range(1, 18)) @(posedge clk);
		end
	endtask

	task automatic load_line(input int unsigned addr, input logic [7:0] bits);
		tcgr_in_t it;
		it = noise_item();
		it.cmd = CMD_LOAD;
		it.font_address = FONT_AW'(addr);
		it.font_bits = bits;
		transfer(it);
	endtask

	task automatic put_char(input logic [7:0] code, input logic [COLOR_W-1:0] fg,
			input logic [COLOR_W-1:0] bg);
		tcgr_in_t it;
		it = noise_item();
		it.cmd = CMD_PUT;
		it.char_code = code;
		it.fg_color = fg;
		it.bg_color = bg;
		transfer(it);
	endtask

	// Stop offering, wait for every owed group, then let queued loads and
	// cursor moves drain out of the block.
	task automatic settle();
		char_if.valid <= 1'b0;
		@(posedge clk);
		while (groups_owed != 0)
			@(posedge clk);
		repeat (20) @(posedge clk);
	endtask

	task automatic put_reg(input cfg_reg_e idx, input int unsigned value);
		cfg_write <= 1'b1;
		cfg_index <= idx;
		cfg_data <= CFG_DATA_W'(value);
		@(posedge clk);
	endtask

	task automatic reconfigure(input int unsigned w, input int unsigned ht,
			input int unsigned pitch, input int unsigned gh, input int unsigned bpp,
			input int unsigned colour);
		settle();
		put_reg(REG_SCREEN_WIDTH, w);
		put_reg(REG_SCREEN_HEIGHT, ht);
		put_reg(REG_LINE_PITCH, pitch);
		put_reg(REG_GLYPH_HEIGHT, gh);
		put_reg(REG_BITS_PER_PIXEL, bpp);
		put_reg(REG_TEXT_COLOR, colour);
		cfg_write <= 1'b0;
		settings.screen_width = SCREEN_W'(w);
		settings.screen_height = SCREEN_W'(ht);
		settings.line_pitch = PITCH_W'(pitch);
		settings.glyph_height = GH_W'(gh);
		settings.bits_per_pixel = BPP_W'(bpp);
		settings.text_color = 8'(colour);
		gap_pct = calm ? 0 : $urandom_range(0, 2) * 20;
		stall_pct = calm ? 0 : $urandom_range(0, 2) * 20;
	endtask

	initial begin
		tcgr_in_t it;
		arst_n <= 1'b0;
		cfg_write <= 1'b0;
		cfg_index <= REG_SCREEN_WIDTH;
		cfg_data <= '0;
		char_if.valid <= 1'b0;
		char_if.data <= '0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed part on a tiny screen: eight columns, two rows, two-line glyphs.
		reconfigure(64, 4, 256, 2, 32, 8'h1F);
		load_line(0, 8'h00);
		load_line(1, 8'hFF);
		load_line(510, 8'hA5);
		load_line(511, 8'h5A);
		it = noise_item();
		it.cmd = CMD_LOAD;
		it.char_code = CHAR_NEWLINE;
		it.font_address = FONT_AW'(FONT_DEPTH - 1);
		it.font_bits = 8'hC3;
		transfer(it);
		put_char(8'd0, 24'hFFFFFF, 24'h000001);
		put_char(8'd255, 24'h000001, 24'hFFFFFF);
		put_char(8'd0, 24'h000000, 24'h123456);
		put_char(8'd255, 24'h654321, 24'h000000);
		put_char(8'd255, 24'h000000, 24'h000000);
		// Tab from column five runs off the line and wraps to the next row.
		put_char(CHAR_TAB, 24'h0, 24'h0);
		put_char(8'd0, 24'($urandom), 24'($urandom));
		// Newline on the last row wraps back to the top.
		put_char(CHAR_NEWLINE, 24'h0, 24'h0);
		repeat (4) put_char(8'd255, 24'($urandom), 24'($urandom));

		// Register defaults; fill glyph 0, then hold the receiver off while
		// characters keep coming so that the block backs up.
		reconfigure(640, 480, 2560, 16, 32, 7);
		variety = 2;
		for (int y = 0; y < 16; y++)
			load_line(y, 8'($urandom));
		hold_output = 1'b1;
		repeat (8) put_char(8'd0, 24'($urandom), 24'($urandom));
		repeat (4) transfer(pick_item(10));

		// Tall glyphs on a huge screen: tabs up to the column limit, then enough
		// newlines that the pixel offset wraps when glyph 0 is drawn.
		reconfigure(8191, 8191, 32767, 32, 32, 8'hF0);
		repeat (64) put_char(CHAR_TAB, 24'($urandom), 24'($urandom));
		repeat (64) put_char(CHAR_NEWLINE, 24'($urandom), 24'($urandom));
		for (int y = 16; y < 32; y++)
			load_line(y, 8'($urandom));
		put_char(8'd0, 24'($urandom), 24'($urandom));
		put_char(8'd0, 24'h000000, 24'($urandom));
		repeat (2) put_char(8'd0, 24'($urandom), 24'($urandom));

		// Settings under which a put draws nothing and leaves the cursor alone.
		variety = 2;
		reconfigure(640, 480, 2560, 16, 0, 7);
		repeat (2) transfer(pick_item(20));
		reconfigure(640, 480, 2560, 16, 31, 7);
		repeat (2) transfer(pick_item(20));
		reconfigure(640, 480, 2560, 0, 32, 7);
		repeat (2) transfer(pick_item(20));
		reconfigure(640, 480, 2560, 33, 32, 7);
		repeat (2) transfer(pick_item(20));
		reconfigure(8191, 8191, 32767, 63, 63, 8'hA5);
		repeat (2) transfer(pick_item(20));
		reconfigure(7, 480, 2560, 16, 32, 7);
		repeat (2) transfer(pick_item(20));
		reconfigure(640, 10, 2560, 16, 32, 7);
		repeat (2) transfer(pick_item(20));
		reconfigure(0, 0, 0, 8, 32, 0);
		repeat (2) transfer(pick_item(20));

		// One-cell screen of one-line glyphs: the old cursor is drawn where it
		// stands, then every put wraps.
		variety = 7;
		reconfigure(8, 1, 0, 1, 32, 8'hFF);
		repeat (6) transfer(pick_item(10));

		// Last stretch with both sides running flat out.
		calm = 1'b1;
		variety = 4;
		reconfigure(4096, 4096, 16384, 8, 32, 8'h00);
		repeat (8) transfer(pick_item(10));

		settle();
		if (mismatches == 0 && groups_owed == 0)
			$display("testbench passed");
		else
			$display("testbench failed");
		$finish;
	end

endmodule

[sim.f]
+incdir+src
src/tcgr_pkg.sv
src/tcgr_stream_if.sv
src/tcgr_fifo.sv
src/tcgr_front.sv
src/tcgr_back.sv
src/text_console_glyph_renderer.sv
tb/sv/glyph_write_checker.sv
tb/sv/testbench.sv
